// ----- rtl/core/vstd_pkg.sv -----
// ----------------------------------------------------------------------------
// vstd_pkg
// Beat types and constants for the serial type varint decoder.
// ----------------------------------------------------------------------------
package vstd_pkg;

  // Longest varint in bytes; the last byte carries all eight bits
  localparam int unsigned MaxVarintBytes = 9;

  // Column type classes
  localparam logic [2:0] CLS_NULL     = 3'd0;
  localparam logic [2:0] CLS_INTEGER  = 3'd1;
  localparam logic [2:0] CLS_FLOAT    = 3'd2;
  localparam logic [2:0] CLS_TEXT     = 3'd3;
  localparam logic [2:0] CLS_BLOB     = 3'd4;
  localparam logic [2:0] CLS_RESERVED = 3'd5;

  // One header byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } byte_beat_t;

  // One decoded varint
  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  byte_count;
    logic [2:0]  type_class;
    logic [62:0] content_length;
    logic        truncated;
  } type_beat_t;

endpackage

// ----- rtl/core/varint_serial_type_decoder.sv -----
// ----------------------------------------------------------------------------
// varint_serial_type_decoder
// Decodes big-endian base-128 record-header varints into type codes.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  byte     | in  | byte_valid/byte_stall  | byte_beat_t: in_byte, buffer_end
//  type     | out | type_valid/type_stall  | type_beat_t: value .. truncated
//
//  One byte beat per cycle unless byte_stall holds it; each byte of a varint
//  passes the input register, then its last byte is decoded into the result
//  register. The accumulate step and the type classify share one cycle.
//  Reset clears the varint state and both valid flags.
//  A stalled result holds; byte_stall rises only when a finishing byte meets
//  a full result register.
// ----------------------------------------------------------------------------
module varint_serial_type_decoder
  import vstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_beat_t byte_data,
  output logic       type_valid,
  input  logic       type_stall,
  output type_beat_t type_data
);

  logic       stage_go;
  logic       stage_valid;
  byte_beat_t stage_data;
  logic       out_free;
  logic       res_valid;
  type_beat_t res_data;

  vstd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .stage_go    (stage_go),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  vstd_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_data  (stage_data),
    .out_free    (out_free),
    .stage_go    (stage_go),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  vstd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res_load   (res_valid && stage_go),
    .res_data   (res_data),
    .out_free   (out_free),
    .type_valid (type_valid),
    .type_stall (type_stall),
    .type_data  (type_data)
  );

endmodule

// ----- rtl/core/vstd_in_reg.sv -----
// ----------------------------------------------------------------------------
// vstd_in_reg
// Input register: holds one header byte beat for the decode stage.
// ----------------------------------------------------------------------------
module vstd_in_reg
  import vstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_beat_t byte_data,
  input  logic       stage_go,
  output logic       stage_valid,
  output byte_beat_t stage_data
);

  // Stall only while the held beat cannot move on
  assign byte_stall = stage_valid && !stage_go;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!byte_stall) begin
      stage_valid <= byte_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      stage_data <= byte_data;
    end
  end

endmodule

// ----- rtl/core/vstd_accum.sv -----
// ----------------------------------------------------------------------------
// vstd_accum
// Varint accumulator: folds in one byte per beat and classifies the code.
// ----------------------------------------------------------------------------
module vstd_accum
  import vstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       stage_valid,
  input  byte_beat_t stage_data,
  input  logic       out_free,
  output logic       stage_go,
  output logic       res_valid,
  output type_beat_t res_data
);

  localparam logic [3:0] LastIdx  = 4'(MaxVarintBytes - 1);
  localparam logic [3:0] MaxCount = 4'(MaxVarintBytes);

  logic [63:0] accumulator;
  logic [3:0]  bytes_seen;
  logic [63:0] accumulator_next;
  logic [3:0]  bytes_seen_next;
  logic        ninth;
  logic        done;
  logic        trunc;
  logic [63:0] code;
  logic [63:0] half_len;
  logic [2:0]  cls;
  logic [62:0] len;

  // Decode the running value
  always_comb begin
    ninth = bytes_seen >= LastIdx;
    if (ninth) begin
      code = {accumulator[55:0], stage_data.in_byte};
    end else begin
      code = {accumulator[56:0], stage_data.in_byte[6:0]};
    end
    done  = ninth || !stage_data.in_byte[7];
    trunc = !done && stage_data.buffer_end;
  end

  // Classify the type code
  always_comb begin
    half_len = (code - (code[0] ? 64'd13 : 64'd12)) >> 1;
    cls      = CLS_NULL;
    len      = '0;
    if (code == 64'd0) begin
      cls = CLS_NULL;
    end else if (code <= 64'd4) begin
      cls = CLS_INTEGER;
      len = 63'(code[2:0]);
    end else if (code == 64'd5) begin
      cls = CLS_INTEGER;
      len = 63'd6;
    end else if (code == 64'd6) begin
      cls = CLS_INTEGER;
      len = 63'd8;
    end else if (code == 64'd7) begin
      cls = CLS_FLOAT;
      len = 63'd8;
    end else if (code == 64'd8 || code == 64'd9) begin
      cls = CLS_INTEGER;
    end else if (code == 64'd10 || code == 64'd11) begin
      cls = CLS_RESERVED;
    end else if (!code[0]) begin
      cls = CLS_BLOB;
      len = half_len[62:0];
    end else begin
      cls = CLS_TEXT;
      len = half_len[62:0];
    end
  end

  // Build the result beat
  always_comb begin
    res_valid = stage_valid && (done || trunc);
    stage_go  = stage_valid && (out_free || !(done || trunc));
    if (trunc) begin
      res_data = '{value: '0, byte_count: '0, type_class: CLS_NULL,
                   content_length: '0, truncated: 1'b1};
    end else begin
      res_data = '{value: code,
                   byte_count: ninth ? MaxCount : 4'(bytes_seen + 4'd1),
                   type_class: cls, content_length: len, truncated: 1'b0};
    end
  end

  // Advance or clear the running state
  always_comb begin
    if (done || trunc) begin
      accumulator_next = '0;
      bytes_seen_next  = '0;
    end else begin
      accumulator_next = code;
      bytes_seen_next  = 4'(bytes_seen + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      bytes_seen  <= '0;
    end else if (stage_go) begin
      accumulator <= accumulator_next;
      bytes_seen  <= bytes_seen_next;
    end
  end

endmodule

// ----- rtl/core/vstd_out_reg.sv -----
// ----------------------------------------------------------------------------
// vstd_out_reg
// Result register: holds one decoded beat until the consumer takes it.
// ----------------------------------------------------------------------------
module vstd_out_reg
  import vstd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       res_load,
  input  type_beat_t res_data,
  output logic       out_free,
  output logic       type_valid,
  input  logic       type_stall,
  output type_beat_t type_data
);

  // Free when empty or draining this cycle
  assign out_free = !type_valid || !type_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      type_valid <= 1'b0;
    end else if (out_free) begin
      type_valid <= res_load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      type_data <= res_data;
    end
  end

endmodule
